/* rtl/core/arpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache and next-hop resolver.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int unsigned IP_W     = 32;
	localparam int unsigned MAC_W    = 48;
	localparam int unsigned ENTRY_W  = IP_W + MAC_W;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ADDRESS = 2'd2;

	localparam logic [IP_W-1:0] LOCAL_ADDRESS_RST   = 32'h0A00_020F;
	localparam logic [IP_W-1:0] SUBNET_MASK_RST     = 32'hFFFF_FF00;
	localparam logic [IP_W-1:0] GATEWAY_ADDRESS_RST = 32'h0A00_0202;

	localparam logic MODE_LEARN   = 1'b0;
	localparam logic MODE_RESOLVE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} arpc_state_t;

endpackage

/* rtl/core/arpc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module arpc_ram #(
	parameter int unsigned WIDTH = 80,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/arp_cache_next_hop_resolver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_next_hop_resolver_core
// Fully associative IPv4-to-MAC cache. Learns from received ARP messages and
// resolves the next hop of a destination against the cache.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Direction  Contents
//  -------   ---------------------  ---------  ---------------------------------
//  in        in_valid / in_ready    into core  mode, ARP fields, destination
//  out       out_valid / out_ready  from core  lookup result or reply request
//  cfg       cfg_we                 into core  local, mask and gateway registers
//
//  The scan reads one cache entry per cycle through the single read port of the
//  entry RAM. Reset clears the valid marks at once; no clearing pass is needed.
//  A finished result sits in the output register, so the next item can be
//  taken while it waits; the core holds in its last step only when the output
//  register is still full.
//
module arp_cache_next_hop_resolver_core
	import arpc_pkg::*;
#(
	parameter int unsigned CACHE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [IP_W-1:0]      sender_address,
	input  logic [MAC_W-1:0]     sender_hw,
	input  logic [IP_W-1:0]      target_address,
	input  logic                 is_request,
	input  logic [IP_W-1:0]      destination,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [IP_W-1:0]      hop_address,
	output logic [MAC_W-1:0]     resolved_hw,
	output logic                 need_request,
	output logic                 send_reply,
	output logic [MAC_W-1:0]     reply_hw,
	output logic [IP_W-1:0]      reply_address,
	output logic                 learn_dropped,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IP_W-1:0]      cfg_data
);

	localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	arpc_state_t state_q, state_d;

	logic [IP_W-1:0] local_address_q, subnet_mask_q, gateway_address_q;

	// Item held for the duration of the scan.
	logic            mode_q;
	logic [IP_W-1:0] key_q;
	logic [MAC_W-1:0] hw_q;
	logic            reply_q;

	logic [CACHE_ENTRIES-1:0] valid_q;

	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_pend_s1;

	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [MAC_W-1:0] match_hw_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic             out_valid_q;
	logic             hit_q, need_request_q, send_reply_q, learn_dropped_q;
	logic [IP_W-1:0]  hop_address_q, reply_address_q;
	logic [MAC_W-1:0] resolved_hw_q, reply_hw_q;

	logic             accept;
	logic             ram_re;
	logic             finish;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [IP_W-1:0]  rd_ip;
	logic [MAC_W-1:0] rd_hw;
	logic             entry_valid;
	logic             entry_match;
	logic [IP_W-1:0]  hop;

	arpc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CACHE_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({key_q, hw_q}),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign rd_ip       = ram_rdata[ENTRY_W-1:MAC_W];
	assign rd_hw       = ram_rdata[MAC_W-1:0];
	assign entry_valid = valid_q[rd_idx_s1];
	assign entry_match = rd_pend_s1 && entry_valid && (rd_ip == key_q);

	assign hop = ((destination & subnet_mask_q) == (local_address_q & subnet_mask_q)) ?
		destination : gateway_address_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		finish    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = free_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN: begin
				ram_re = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				finish = !out_valid_q || out_ready;
				if (mode_q == MODE_LEARN) begin
					ram_we    = finish && (found_q || free_found_q);
					ram_waddr = found_q ? match_idx_q : free_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			local_address_q   <= LOCAL_ADDRESS_RST;
			subnet_mask_q     <= SUBNET_MASK_RST;
			gateway_address_q <= GATEWAY_ADDRESS_RST;
			valid_q           <= '0;
			rd_idx_q          <= '0;
			rd_pend_s1        <= 1'b0;
			found_q           <= 1'b0;
			free_found_q      <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOCAL_ADDRESS:   local_address_q   <= cfg_data;
					REG_SUBNET_MASK:     subnet_mask_q     <= cfg_data;
					REG_GATEWAY_ADDRESS: gateway_address_q <= cfg_data;
					default: begin
					end
				endcase
			end

			rd_pend_s1 <= ram_re;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (ram_re && rd_idx_q != LAST_IDX) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end

			// The first valid match and the first free entry are both kept.
			if (accept) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (rd_pend_s1) begin
				if (entry_match && !found_q) begin
					found_q <= 1'b1;
				end
				if (!entry_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			if (finish && mode_q == MODE_LEARN && !found_q && free_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end

			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (accept) begin
			mode_q  <= mode;
			key_q   <= (mode == MODE_LEARN) ? sender_address : hop;
			hw_q    <= sender_hw;
			reply_q <= is_request && (target_address == local_address_q);
		end
		if (entry_match && !found_q) begin
			match_idx_q <= rd_idx_s1;
			match_hw_q  <= rd_hw;
		end
		if (rd_pend_s1 && !entry_valid && !free_found_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (finish) begin
			if (mode_q == MODE_LEARN) begin
				hit_q           <= 1'b0;
				hop_address_q   <= '0;
				resolved_hw_q   <= '0;
				need_request_q  <= 1'b0;
				send_reply_q    <= reply_q;
				reply_hw_q      <= reply_q ? hw_q : '0;
				reply_address_q <= reply_q ? key_q : '0;
				learn_dropped_q <= !found_q && !free_found_q;
			end else begin
				hit_q           <= found_q;
				hop_address_q   <= key_q;
				resolved_hw_q   <= found_q ? match_hw_q : '0;
				need_request_q  <= !found_q;
				send_reply_q    <= 1'b0;
				reply_hw_q      <= '0;
				reply_address_q <= '0;
				learn_dropped_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign hop_address   = hop_address_q;
	assign resolved_hw   = resolved_hw_q;
	assign need_request  = need_request_q;
	assign send_reply    = send_reply_q;
	assign reply_hw      = reply_hw_q;
	assign reply_address = reply_address_q;
	assign learn_dropped = learn_dropped_q;

endmodule

/* rtl/core/arpc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on the ARP cache and next-hop resolver.
// ----------------------------------------------------------------------------
module arpc_checker
	import arpc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             hit,
	input logic [IP_W-1:0]  hop_address,
	input logic [MAC_W-1:0] resolved_hw,
	input logic             need_request,
	input logic             send_reply,
	input logic [MAC_W-1:0] reply_hw,
	input logic [IP_W-1:0]  reply_address,
	input logic             learn_dropped
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hop_address) &&
			$stable(resolved_hw) && $stable(send_reply) && $stable(learn_dropped))
		else $error("result item changed while stalled");

	// The core is busy scanning right after it takes an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while scan in progress");

	// A result never flags both a hit and a miss.
	a_hit_xor_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit || need_request) |-> hit != need_request)
		else $error("hit and need_request both set");

	// Resolve results carry nothing from learn mode.
	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit || need_request) |->
			!send_reply && !learn_dropped && reply_hw == '0 && reply_address == '0)
		else $error("learn fields set in a resolve result");

	// A miss never reports a MAC.
	a_miss_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> resolved_hw == '0)
		else $error("MAC reported without a hit");

endmodule

bind arp_cache_next_hop_resolver_core arpc_checker u_arpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.hit           (hit),
	.hop_address   (hop_address),
	.resolved_hw   (resolved_hw),
	.need_request  (need_request),
	.send_reply    (send_reply),
	.reply_hw      (reply_hw),
	.reply_address (reply_address),
	.learn_dropped (learn_dropped)
);
